// ----- rtl/efrp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// efrp_pkg
// Shared constants and helpers for the F3 relation projection block.
// ----------------------------------------------------------------------------
package efrp_pkg;

  localparam int MAX_VERTICES   = 64;
  localparam int STORE_DEPTH    = 128;
  localparam int INTERNAL_LIMIT = 20;

  localparam int VTX_W   = 6;
  localparam int COEF_W  = 2;
  localparam int REL_W   = 2 * VTX_W + 4 * COEF_W;
  localparam int REL_AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
  localparam int KCNT_W  = 7;
  localparam int MASK_W  = 4;
  localparam int TRIED_W = 23;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_EXT_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT_MASK   = 2'd2;

  // Vertices that exist in this build.
  localparam logic [63:0] VRANGE = {64{1'b1}} >> (64 - MAX_VERTICES);

  // A relation holds when c0 + c1*x + c2*y + c3*x*y is a multiple of three.
  function automatic logic rel_holds(input logic [REL_W-1:0] rel,
                                     input logic [63:0] vals);
    logic       x;
    logic       y;
    logic [3:0] s;
    x = vals[rel[VTX_W-1:0]];
    y = vals[rel[2*VTX_W-1:VTX_W]];
    s = 4'(rel[13:12])
        + (x ? 4'(rel[15:14]) : 4'd0)
        + (y ? 4'(rel[17:16]) : 4'd0)
        + ((x && y) ? 4'(rel[19:18]) : 4'd0);
    rel_holds = s inside {4'd0, 4'd3, 4'd6, 4'd9, 4'd12};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/exhaustive_f3_relation_projection_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// exhaustive_f3_relation_projection_top
// Stores F3 relations and, at the end of a batch, enumerates every Boolean
// assignment of the internal vertices for each external value pair.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Moves
// s_*       in   s_tvalid / s_tready    one relation per transfer, tlast ends batch
// m_*       out  m_tvalid / m_tready    one result per batch
// cfg_*     in   cfg_valid / cfg_ready  one register write per transfer
//
// Relations load at one per cycle into a 128-entry synchronous memory. The
// transfer that carries tlast starts a count of internal vertices over all 64
// vertex slots, followed by the walk over up to 4 * 2^k assignments for k
// internal vertices: each relation test costs one memory read, and the walk
// moves on when a relation fails or an external pair is found satisfiable.
// The input stalls from the tlast transfer until the result enters the output
// register; a result waiting on m_tready does not block the next batch from
// loading. Reset is synchronous; the relation memory is not cleared, since
// only entries written in the current batch are ever read.
module exhaustive_f3_relation_projection_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // vertex_a[5:0], vertex_b[11:6], coef_const[13:12], coef_a[15:14],
  // coef_b[17:16], coef_ab[19:18], zero fill [23:20]
  input  wire logic [efrp_pkg::S_DATA_W-1:0]     s_tdata,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // sat_mask[3:0], performed[4], tried_count[27:5], overflow[28],
  // zero fill [31:29]
  output logic [efrp_pkg::M_DATA_W-1:0]          m_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [efrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [efrp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_COUNT = 4'b0010,
    S_ENUM  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [efrp_pkg::VTX_W-1:0] ext_first;
  logic [efrp_pkg::VTX_W-1:0] ext_second;
  logic [63:0]                internal_mask;

  // Batch bookkeeping.
  logic [efrp_pkg::CNT_W-1:0] rel_count;
  logic                       ovf;

  // Relation memory and its read port.
  logic [efrp_pkg::REL_W-1:0] mem [efrp_pkg::STORE_DEPTH];
  logic [efrp_pkg::REL_W-1:0] rdata;
  logic                       mem_we;

  // Count phase.
  logic [efrp_pkg::VTX_W-1:0]  cidx;
  logic [efrp_pkg::KCNT_W-1:0] kcnt;
  logic [efrp_pkg::KCNT_W-1:0] k_sum;

  // Walk state.
  logic [1:0]                 pq;
  logic [63:0]                sub;
  logic [63:0]                sub_next;
  logic [efrp_pkg::CNT_W-1:0] ra;
  logic [efrp_pkg::CNT_W-1:0] pidx;
  logic                       pend;
  logic [63:0]                imask;
  logic [63:0]                vals;
  logic                       holds;

  // Result being built.
  logic [efrp_pkg::MASK_W-1:0]  zmask;
  logic                         perf;
  logic [efrp_pkg::TRIED_W-1:0] tried;

  logic s_xfer;
  logic full;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_LOAD);
  assign s_xfer    = s_tvalid && s_tready;
  assign full      = (rel_count == efrp_pkg::CNT_W'(efrp_pkg::STORE_DEPTH));
  assign mem_we    = s_xfer && !full;
  assign imask     = internal_mask & efrp_pkg::VRANGE;
  assign k_sum     = kcnt + efrp_pkg::KCNT_W'(imask[cidx]);

  // Next subset of the internal vertices; wraps to zero after the last one.
  assign sub_next = ((sub | ~imask) + 64'd1) & imask;

  // Vertex values for the current external pair and internal assignment.
  // The second external overrides the first, internals override both.
  always_comb begin
    vals = '0;
    if (efrp_pkg::VRANGE[ext_first] && pq[0]) begin
      vals[ext_first] = 1'b1;
    end
    if (efrp_pkg::VRANGE[ext_second]) begin
      vals[ext_second] = pq[1];
    end
    vals = (vals & ~imask) | sub;
  end

  assign holds = efrp_pkg::rel_holds(rdata, vals);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[rel_count[efrp_pkg::REL_AW-1:0]] <= s_tdata[efrp_pkg::REL_W-1:0];
    end
    rdata <= mem[ra[efrp_pkg::REL_AW-1:0]];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_first     <= '0;
      ext_second    <= efrp_pkg::VTX_W'(1);
      internal_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        efrp_pkg::REG_EXT_FIRST:  ext_first     <= cfg_data[efrp_pkg::VTX_W-1:0];
        efrp_pkg::REG_EXT_SECOND: ext_second    <= cfg_data[efrp_pkg::VTX_W-1:0];
        efrp_pkg::REG_INT_MASK:   internal_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      rel_count <= '0;
      ovf       <= 1'b0;
      m_tvalid  <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded whenever it drains.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (s_xfer) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              rel_count <= rel_count + 1'b1;
            end
            if (s_tlast) begin
              cidx  <= '0;
              kcnt  <= '0;
              state <= S_COUNT;
            end
          end
        end
        S_COUNT: begin
          kcnt <= k_sum;
          cidx <= cidx + 1'b1;
          if (cidx == efrp_pkg::VTX_W'(efrp_pkg::MAX_VERTICES - 1)) begin
            zmask <= '0;
            pq    <= '0;
            sub   <= '0;
            ra    <= '0;
            pend  <= 1'b0;
            if (k_sum <= efrp_pkg::KCNT_W'(efrp_pkg::INTERNAL_LIMIT)) begin
              perf  <= 1'b1;
              tried <= efrp_pkg::TRIED_W'(1) << (8'(k_sum) + 8'd2);
              state <= S_ENUM;
            end else begin
              perf  <= 1'b0;
              tried <= '0;
              state <= S_DONE;
            end
          end
        end
        S_ENUM: begin
          if (pend && !holds) begin
            // A relation failed: drop the read in flight, next assignment.
            ra   <= '0;
            pend <= 1'b0;
            sub  <= sub_next;
            if (sub_next == '0) begin
              if (pq == 2'd3) begin
                state <= S_DONE;
              end else begin
                pq <= pq + 1'b1;
              end
            end
          end else if (pend && (pidx == rel_count - 1'b1)) begin
            // Every relation held: this external pair is satisfiable.
            zmask[pq] <= 1'b1;
            ra        <= '0;
            pend      <= 1'b0;
            sub       <= '0;
            if (pq == 2'd3) begin
              state <= S_DONE;
            end else begin
              pq <= pq + 1'b1;
            end
          end else if (ra < rel_count) begin
            pend <= 1'b1;
            pidx <= ra;
            ra   <= ra + 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= {3'b000, ovf, tried, perf, zmask};
            rel_count <= '0;
            ovf       <= 1'b0;
            state     <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/efrp_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// efrp_checker
// Port-level checks for the F3 relation projection block.
// ----------------------------------------------------------------------------
module efrp_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [efrp_pkg::M_DATA_W-1:0]   m_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // No enumeration means an empty mask and a zero count.
  a_not_performed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[4] |-> (m_tdata[3:0] == 4'd0) && (m_tdata[27:5] == 23'd0))
    else $error("mask or count set without enumeration");

  // A performed enumeration always reports at least four assignments.
  a_performed_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> (m_tdata[6:5] == 2'd0) && (m_tdata[27:5] != 23'd0))
    else $error("bad assignment count");

  // The fill bits of the result stay zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:29] == 3'd0))
    else $error("fill bits set");

  // No result directly after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind exhaustive_f3_relation_projection_top efrp_checker u_efrp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the F3 relation projection block. Batches of
// relations stream in on the s_* channel, and each batch ends with a tlast
// transfer. A predictor in the bench stores the relations in the same way
// and works out the satisfiable external pairs by its own enumeration. Each
// result transfer on m_* is compared with the oldest prediction. The run
// covers directed corner batches and then random phases with different
// register settings and different idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;

  // The run is stopped here if it hangs. A correct run needs a small
  // fraction of this time.
  localparam longint RUN_LIMIT_NS = 8_000_000;
  localparam int     SETTLE_CYCLES = 100;
  // The count of internal vertices alone walks all 64 vertex slots.
  localparam int     QUIET_CYCLES = 70;

  // One relation as it travels on the input channel.
  typedef struct packed {
    logic [efrp_pkg::VTX_W-1:0]  vertex_a;
    logic [efrp_pkg::VTX_W-1:0]  vertex_b;
    logic [efrp_pkg::COEF_W-1:0] coef_const;
    logic [efrp_pkg::COEF_W-1:0] coef_a;
    logic [efrp_pkg::COEF_W-1:0] coef_b;
    logic [efrp_pkg::COEF_W-1:0] coef_ab;
    logic                        last;
  } relation_t;

  // One batch result, with fields unpacked from m_tdata.
  typedef struct packed {
    logic [efrp_pkg::MASK_W-1:0]  sat_mask;
    logic                         performed;
    logic [efrp_pkg::TRIED_W-1:0] tried_count;
    logic                         overflow;
  } projection_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [efrp_pkg::S_DATA_W-1:0]   s_tdata;
  logic                            s_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [efrp_pkg::M_DATA_W-1:0]   m_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [efrp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [efrp_pkg::CFG_DATA_W-1:0] cfg_data;

  exhaustive_f3_relation_projection_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Relations waiting to be driven, and projections waiting to come out.
  relation_t   pending_relations[$];
  projection_t expected_projections[$];
  relation_t   driven_relation;

  // The predictor keeps its own copy of the relation store and registers.
  relation_t   relation_mem[efrp_pkg::STORE_DEPTH];
  int          relations_held = 0;
  bit          relations_dropped = 1'b0;
  logic [5:0]  ext_first_reg = 6'd0;
  logic [5:0]  ext_second_reg = 6'd1;
  logic [63:0] internal_set = 64'd0;

  // Vertices that the current setting makes interesting for random batches.
  int          hot_vertices[$];

  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  bit          relation_taken = 1'b0;
  int          mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // True when every stored relation of the batch is zero mod 3 under vals.
  function automatic bit batch_holds(input logic [63:0] vals);
    relation_t r;
    int        x;
    int        y;
    int        s;
    for (int i = 0; i < relations_held; i++) begin
      r = relation_mem[i];
      x = vals[r.vertex_a];
      y = vals[r.vertex_b];
      s = int'(r.coef_const) + int'(r.coef_a) * x + int'(r.coef_b) * y
          + int'(r.coef_ab) * x * y;
      if (s % 3 != 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // For each external pair, search the internal assignments for one that
  // satisfies the whole batch. The internal value overrides an external one,
  // and when both externals name the same vertex, the second one (q) wins.
  function automatic projection_t project_batch();
    projection_t res;
    int          members[64];
    int          k;
    longint      span;
    logic [63:0] vals;
    res = '0;
    k = 0;
    for (int v = 0; v < 64; v++) begin
      if (internal_set[v] && efrp_pkg::VRANGE[v]) begin
        members[k] = v;
        k++;
      end
    end
    if (k <= efrp_pkg::INTERNAL_LIMIT) begin
      res.performed = 1'b1;
      span = longint'(1) << k;
      res.tried_count = efrp_pkg::TRIED_W'(4 * span);
      for (int pair = 0; pair < 4; pair++) begin
        for (longint a = 0; a < span; a++) begin
          vals = '0;
          vals[ext_first_reg] = pair[0];
          vals[ext_second_reg] = pair[1];
          for (int j = 0; j < k; j++) vals[members[j]] = a[j];
          if (batch_holds(vals)) begin
            res.sat_mask[pair] = 1'b1;
            break;
          end
        end
      end
    end
    res.overflow = relations_dropped;
    return res;
  endfunction

  // Store an accepted relation. A full store drops it and flags the batch.
  // The final relation of a batch yields one expected projection.
  task automatic absorb_relation(input relation_t r);
    if (relations_held < efrp_pkg::STORE_DEPTH) begin
      relation_mem[relations_held] = r;
      relations_held++;
    end else begin
      relations_dropped = 1'b1;
    end
    if (r.last) begin
      expected_projections.push_back(project_batch());
      relations_held = 0;
      relations_dropped = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_projection(input logic [efrp_pkg::M_DATA_W-1:0] data);
    projection_t got;
    projection_t want;
    got.sat_mask    = data[3:0];
    got.performed   = data[4];
    got.tried_count = data[27:5];
    got.overflow    = data[28];
    if (expected_projections.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with nothing expected", data));
    end else begin
      want = expected_projections.pop_front();
      if (got.sat_mask !== want.sat_mask)
        report_mismatch($sformatf("sat_mask %b, expected %b", got.sat_mask,
                                  want.sat_mask));
      if (got.performed !== want.performed)
        report_mismatch($sformatf("performed %b, expected %b", got.performed,
                                  want.performed));
      if (got.tried_count !== want.tried_count)
        report_mismatch($sformatf("tried_count %0d, expected %0d", got.tried_count,
                                  want.tried_count));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("overflow %b, expected %b", got.overflow,
                                  want.overflow));
    end
  endtask

  // The monitor samples both channels at the rising edge. A relation transfer
  // goes to the predictor, and a result transfer is checked against the queue.
  always @(posedge clk) begin
    if (rst) begin
      relation_taken <= 1'b0;
    end else begin
      relation_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) check_projection(m_tdata);
      if (s_tvalid && s_tready)
        absorb_relation('{vertex_a:   s_tdata[5:0],
                          vertex_b:   s_tdata[11:6],
                          coef_const: s_tdata[13:12],
                          coef_a:     s_tdata[15:14],
                          coef_b:     s_tdata[17:16],
                          coef_ab:    s_tdata[19:18],
                          last:       s_tlast});
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // The driver holds a relation until its transfer has been seen. After that
  // it either presents the next pending relation or idles.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || relation_taken) begin
        if (pending_relations.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          driven_relation = pending_relations.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0000, driven_relation.coef_ab, driven_relation.coef_b,
                       driven_relation.coef_a, driven_relation.coef_const,
                       driven_relation.vertex_b, driven_relation.vertex_a};
          s_tlast  <= driven_relation.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // The receiver stalls at random, at the rate that the current phase sets.
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_relation(input int va, input int vb, input int c0,
                                input int ca, input int cb, input int cab,
                                input bit last);
    pending_relations.push_back('{vertex_a: efrp_pkg::VTX_W'(va),
                                  vertex_b: efrp_pkg::VTX_W'(vb),
                                  coef_const: efrp_pkg::COEF_W'(c0),
                                  coef_a: efrp_pkg::COEF_W'(ca),
                                  coef_b: efrp_pkg::COEF_W'(cb),
                                  coef_ab: efrp_pkg::COEF_W'(cab),
                                  last: last});
  endtask

  // Wait until every relation has been taken and every result has arrived.
  task automatic wait_until_idle();
    while (!(pending_relations.size() == 0 && !s_tvalid &&
             expected_projections.size() == 0))
      @(posedge clk);
  endtask

  // One write on the configuration channel. The predictor takes the new value
  // at the same edge as the block does.
  task automatic write_register(input logic [efrp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [efrp_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      efrp_pkg::REG_EXT_FIRST:  ext_first_reg = value[5:0];
      efrp_pkg::REG_EXT_SECOND: ext_second_reg = value[5:0];
      efrp_pkg::REG_INT_MASK:   internal_set = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only once the block has gone quiet after its last batch.
  task automatic program_registers(input logic [5:0] first, input logic [5:0] second,
                                   input logic [63:0] internals);
    wait_until_idle();
    repeat (QUIET_CYCLES) @(posedge clk);
    write_register(efrp_pkg::REG_EXT_FIRST, 64'(first));
    write_register(efrp_pkg::REG_EXT_SECOND, 64'(second));
    write_register(efrp_pkg::REG_INT_MASK, internals);
    hot_vertices.delete();
    hot_vertices.push_back(first);
    hot_vertices.push_back(second);
    for (int v = 0; v < 64; v++)
      if (internals[v]) hot_vertices.push_back(v);
  endtask

  function automatic int pick_vertex();
    if ($urandom_range(99) < 70)
      return hot_vertices[$urandom_range(hot_vertices.size() - 1)];
    return $urandom_range(63);
  endfunction

  // A random batch of n relations. Most batches are built around a hidden
  // assignment that satisfies all of them, so that satisfiable pairs turn up
  // often. The rest have free coefficients and are mostly unsatisfiable.
  task automatic queue_random_batch(input int n);
    bit          planted;
    logic [63:0] hidden;
    int          va;
    int          vb;
    int          ca;
    int          cb;
    int          cab;
    int          c0;
    planted = ($urandom_range(99) < 60);
    hidden = {$urandom, $urandom} &
             (internal_set | (64'd1 << ext_first_reg) | (64'd1 << ext_second_reg));
    for (int i = 0; i < n; i++) begin
      va  = pick_vertex();
      vb  = pick_vertex();
      ca  = $urandom_range(3);
      cb  = $urandom_range(3);
      cab = $urandom_range(3);
      if (planted)
        c0 = (3 - (ca * hidden[va] + cb * hidden[vb] + cab * hidden[va] * hidden[vb]) % 3)
             % 3;
      else
        c0 = $urandom_range(3);
      queue_relation(va, vb, c0, ca, cb, cab, i == n - 1);
    end
  endtask

  initial begin
    int          phase_items;
    int          n;
    int          k;
    logic [5:0]  first;
    logic [5:0]  second;
    logic [63:0] internals;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = efrp_pkg::REG_EXT_FIRST;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with no idling on either side.
    // Registers still at their reset values: 1 + x + y is zero only for x = y = 1.
    queue_relation(0, 1, 1, 1, 1, 0, 1'b1);

    // Two internal vertices. Coefficients of three act as zero, and a relation
    // on one vertex uses the same value at both ends.
    program_registers(6'd0, 6'd1, (64'd1 << 2) | (64'd1 << 3));
    queue_relation(2, 3, 3, 3, 3, 3, 1'b0);
    queue_relation(2, 2, 2, 1, 0, 0, 1'b1);
    // Two relations that need opposite values of one internal vertex.
    queue_relation(2, 2, 2, 1, 0, 0, 1'b0);
    queue_relation(2, 2, 0, 1, 0, 0, 1'b1);
    // Vertex 63 is neither external nor internal, so it reads zero.
    queue_relation(63, 63, 3, 3, 3, 3, 1'b0);
    queue_relation(63, 0, 2, 2, 2, 2, 1'b1);

    // Both externals name the same vertex, which then takes the value q.
    program_registers(6'd63, 6'd63, 64'd0);
    queue_relation(63, 63, 1, 2, 0, 0, 1'b1);

    // An external vertex that is also internal takes the enumerated value.
    program_registers(6'd5, 6'd6, (64'd1 << 5) | (64'd1 << 63));
    queue_relation(5, 5, 2, 1, 0, 0, 1'b0);
    queue_relation(6, 6, 0, 1, 0, 0, 1'b0);
    queue_relation(63, 5, 0, 1, 1, 1, 1'b1);

    // Exactly the internal limit. The relations always hold, so each pair is
    // found on its first assignment while the count still reports all of them.
    program_registers(6'd0, 6'd1, 64'hFFFFF << 40);
    queue_relation(40, 59, 0, 0, 0, 0, 1'b0);
    queue_relation(0, 1, 3, 0, 0, 3, 1'b1);

    // One internal vertex too many, and then every vertex internal: no walk.
    program_registers(6'd0, 6'd1, 64'h1FFFFF << 40);
    queue_relation(0, 1, 0, 0, 0, 0, 1'b1);
    program_registers(6'd0, 6'd1, {64{1'b1}});
    queue_relation(63, 0, 1, 1, 1, 1, 1'b1);

    // Random phases. Each phase has its own setting and idle pattern, and the
    // odd phases carry one long batch around the store capacity.
    for (int phase = 0; phase < 8; phase++) begin
      first  = (phase == 0) ? 6'd63 : 6'($urandom_range(63));
      second = (phase == 2) ? first : (phase == 4) ? 6'd0 : 6'($urandom_range(63));
      if (phase == 6) begin
        internals = {$urandom, $urandom};
        if ($countones(internals) <= efrp_pkg::INTERNAL_LIMIT) internals = ~internals;
      end else begin
        internals = '0;
        k = $urandom_range((phase % 2 == 1) ? 3 : 5);
        repeat (k) internals[$urandom_range(63)] = 1'b1;
      end
      program_registers(first, second, internals);

      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 45;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 45;
        end
        default: begin
          sender_idle_pct = 11;
          receiver_stall_pct = 11;
        end
      endcase

      phase_items = 0;
      if (phase % 2 == 1) begin
        // Lengths 127, 128, 129 and 130 across the odd phases.
        n = efrp_pkg::STORE_DEPTH + phase / 2 - 1;
        queue_random_batch(n);
        phase_items += n;
      end
      while (phase_items < 150) begin
        n = ($urandom_range(99) < 20) ? 1 : $urandom_range(2, 6);
        queue_random_batch(n);
        phase_items += n;
      end
    end

    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_projections.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_projections.size()));
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/efrp_pkg.sv
rtl/exhaustive_f3_relation_projection_top.sv
rtl/efrp_checker.sv
test/testbench.sv
